[hdl/pvbd_pkg.sv]
// Package for the prefix varint bit decoder: word types, decoder state and codes.
// Used by pvbd_step and by the top level prefix_varint_bit_decoder.
package pvbd_pkg;

  localparam int unsigned ShortBits  = 2;
  localparam int unsigned LongBits   = 8;
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    PHASE_PREFIX = 2'd0,
    PHASE_SHORT  = 2'd1,
    PHASE_LONG   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       realign;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } out_word_t;

  typedef struct packed {
    phase_t      code_phase;
    logic [3:0]  bits_remaining;
    logic [7:0]  code_bits;
    logic [1:0]  group_index;
    logic [31:0] group_value;
  } dec_state_t;

  typedef struct packed {
    logic [1:0]                  count;
    logic [MaxResults-1:0][31:0] values;
  } step_result_t;

endpackage

[hdl/pvbd_step.sv]
// Decodes one stream byte against the current decoder state, bit by bit.
// Depends on pvbd_pkg for the state and result types.
module pvbd_step (
  input  logic [7:0]           data_byte,
  input  logic                 realign,
  input  logic [1:0]           codes_per_value_log2,
  input  pvbd_pkg::dec_state_t state_cur,
  output pvbd_pkg::dec_state_t state_next,
  output pvbd_pkg::step_result_t result
);
  import pvbd_pkg::*;

  logic [1:0] last_slot;

  // A setting of three behaves as four codes per value.
  always_comb begin
    unique case (codes_per_value_log2)
      2'd0:    last_slot = 2'd0;
      2'd1:    last_slot = 2'd1;
      default: last_slot = 2'd3;
    endcase
  end

  always_comb begin
    dec_state_t  st;
    logic [1:0]  cnt;
    logic        b;
    logic [7:0]  code;
    logic [3:0]  rem;
    logic [31:0] gv;
    st = state_cur;
    cnt = 2'd0;
    b = 1'b0;
    code = 8'd0;
    rem = 4'd0;
    gv = 32'd0;
    result.values = '0;
    if (realign) begin
      st.code_phase     = PHASE_PREFIX;
      st.bits_remaining = 4'd0;
      st.code_bits      = 8'd0;
      st.group_index    = 2'd0;
      st.group_value    = 32'd0;
    end
    for (int k = 7; k >= 0; k--) begin
      b = data_byte[3'(k)];
      case (st.code_phase)
        PHASE_SHORT, PHASE_LONG: begin
          code = {st.code_bits[6:0], b};
          rem  = st.bits_remaining - 4'd1;
          st.code_bits      = code;
          st.bits_remaining = rem;
          if (rem == 4'd0) begin
            st.code_phase = PHASE_PREFIX;
            gv = st.group_value | ({24'd0, code} << {st.group_index, 3'b000});
            if (st.group_index >= last_slot) begin
              if (cnt < 2'(MaxResults)) begin
                result.values[cnt] = gv;
                cnt = cnt + 2'd1;
              end
              st.group_value = 32'd0;
              st.group_index = 2'd0;
            end else begin
              st.group_value = gv;
              st.group_index = st.group_index + 2'd1;
            end
            st.code_bits = 8'd0;
          end
        end
        default: begin
          // A prefix bit picks the length of the code that follows.
          st.code_phase     = b ? PHASE_LONG : PHASE_SHORT;
          st.bits_remaining = b ? 4'(LongBits) : 4'(ShortBits);
          st.code_bits      = 8'd0;
        end
      endcase
    end
    state_next   = st;
    result.count = cnt;
  end

endmodule

[hdl/prefix_varint_bit_decoder.sv]
// Top level of the prefix varint bit decoder: input register, decode, result buffer.
// Depends on pvbd_pkg and pvbd_step.
//
// Usage: stream bytes enter on the in channel (in_valid, in_stall, in_word) and
// decoded values leave on the out channel (out_valid, out_stall, out_word), one
// value per word. Each value's last bit marks the final value that its input
// byte produced; a byte that finishes no value produces no word.
// A byte is registered on acceptance and decoded from the input register into
// a three-entry result buffer once the buffer is free; the buffer register
// then offers its first value. The buffer drains one value per cycle while
// out_stall is low, and a byte finishes at most three values, all through the
// single output port. The next byte is decoded in the cycle the buffer's last
// value is taken, so bytes with at most one value flow every cycle while
// out_stall is low.
// The user writes the codes_per_value_log2 register through cfg_write and cfg_data
// only while the block is idle; the block does not enforce this. Reset clears the
// register, the decoder state and all pending words. While out_stall is high the
// output word holds, the buffer and the input register fill, then in_stall rises.
module prefix_varint_bit_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pvbd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pvbd_pkg::out_word_t out_word,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_data
);
  import pvbd_pkg::*;

  logic                        s1_valid;
  in_word_t                    s1_word;
  dec_state_t                  state;
  dec_state_t                  state_next;
  step_result_t                step_res;
  logic [1:0]                  codes_per_value_log2;
  logic [MaxResults-1:0][31:0] buf_values;
  logic [1:0]                  buf_count;
  logic [1:0]                  buf_rd;
  logic                        out_take;
  logic                        buf_free;
  logic                        s1_move;
  logic                        rd_last;

  pvbd_step u_step (
    .data_byte            (s1_word.data_byte),
    .realign              (s1_word.realign),
    .codes_per_value_log2 (codes_per_value_log2),
    .state_cur            (state),
    .state_next           (state_next),
    .result               (step_res)
  );

  assign out_valid      = (buf_count != 2'd0);
  assign rd_last        = (buf_rd == buf_count - 2'd1);
  assign out_word.value = buf_values[buf_rd];
  assign out_word.last  = rd_last;
  assign out_take       = out_valid && !out_stall;
  assign buf_free       = !out_valid || (out_take && rd_last);
  assign s1_move        = s1_valid && buf_free;
  assign in_stall       = s1_valid && !buf_free;

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_word <= in_word;
    end
    if (s1_move) begin
      buf_values <= step_res.values;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      buf_count            <= 2'd0;
      buf_rd               <= 2'd0;
      codes_per_value_log2 <= 2'd0;
      state                <= '{code_phase: PHASE_PREFIX, default: '0};
    end else begin
      if (cfg_write) begin
        codes_per_value_log2 <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_move) begin
        state     <= state_next;
        buf_count <= step_res.count;
        buf_rd    <= 2'd0;
      end else if (out_take) begin
        if (rd_last) begin
          buf_count <= 2'd0;
        end else begin
          buf_rd <= buf_rd + 2'd1;
        end
      end
    end
  end

endmodule

[hdl/pvbd_checker.sv]
// Port-level checks for prefix_varint_bit_decoder, bound to the top level.
// Depends on pvbd_pkg for the output word type.
module pvbd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pvbd_pkg::out_word_t out_word
);
  import pvbd_pkg::*;

  // A stalled output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // The input side only backs up behind pending results.
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // Taking the last value of a byte must free the input side in the same cycle.
  a_stall_not_last: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |-> !out_word.last)
    else $error("input stalled while last value is taken");

endmodule

bind prefix_varint_bit_decoder pvbd_checker u_pvbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[sim/prefix_varint_bit_decoder_tb.sv]
// Self-checking testbench for prefix_varint_bit_decoder: a queued byte driver, a
// result monitor and an in-line predictor of the bit-stream decode and grouping.
// Depends on pvbd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module prefix_varint_bit_decoder_tb;
  import pvbd_pkg::*;

  localparam logic [1:0] PerValueByte    = 2'd0;
  localparam logic [1:0] PerValueHalf    = 2'd1;
  localparam logic [1:0] PerValueWord    = 2'd2;
  localparam logic [1:0] PerValueClamped = 2'd3;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_write;
  logic [1:0] cfg_data;

  prefix_varint_bit_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_word_t  pending_bytes[$];
  out_word_t expected_values[$];
  int        error_count = 0;
  int        results_seen = 0;
  logic      word_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Predictor state, a copy of what the block keeps between bytes.
  phase_t      dec_phase;
  logic [3:0]  dec_left;
  logic [7:0]  dec_bits;
  logic [1:0]  dec_slot;
  logic [31:0] dec_partial;
  logic [1:0]  per_value_log2;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_partial();
    dec_phase   = PHASE_PREFIX;
    dec_left    = '0;
    dec_bits    = '0;
    dec_slot    = '0;
    dec_partial = '0;
  endfunction

  // Walks the byte MSB first and queues every value it finishes.
  function automatic void decode_byte(input in_word_t w);
    logic      bit_now;
    logic [1:0] lg;
    logic [1:0] top_slot;
    int        produced;
    out_word_t res;
    produced = 0;
    if (w.realign) clear_partial();
    for (int k = 7; k >= 0; k--) begin
      bit_now = w.data_byte[k];
      if (dec_phase == PHASE_PREFIX) begin
        dec_phase = bit_now ? PHASE_LONG : PHASE_SHORT;
        dec_left  = bit_now ? 4'(LongBits) : 4'(ShortBits);
        dec_bits  = '0;
      end else begin
        dec_bits = {dec_bits[6:0], bit_now};
        dec_left = dec_left - 4'd1;
        if (dec_left == 4'd0) begin
          dec_phase = PHASE_PREFIX;
          // A setting of three groups four codes, like a setting of two.
          lg = (per_value_log2 > PerValueWord) ? PerValueWord : per_value_log2;
          top_slot = 2'((1 << lg) - 1);
          dec_partial |= 32'(dec_bits) << (8 * dec_slot);
          if (dec_slot >= top_slot) begin
            if (produced < MaxResults) begin
              res.value = dec_partial;
              res.last  = 1'b0;
              expected_values.push_back(res);
              produced++;
            end
            dec_partial = '0;
            dec_slot    = '0;
          end else begin
            dec_slot = dec_slot + 2'd1;
          end
          dec_bits = '0;
        end
      end
    end
    if (produced > 0) begin
      res = expected_values.pop_back();
      res.last = 1'b1;
      expected_values.push_back(res);
    end
  endfunction

  // Monitor: register writes, accepted bytes and accepted results, all at the rising edge.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      per_value_log2 = PerValueByte;
      clear_partial();
      word_taken <= 1'b0;
    end else begin
      if (cfg_write) per_value_log2 = cfg_data;
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) decode_byte(in_word);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("unexpected word: value %h last %b",
                                    out_word.value, out_word.last));
        end else begin
          want = expected_values.pop_front();
          if (out_word.value !== want.value)
            report_mismatch($sformatf("value: got %h, expected %h",
                                      out_word.value, want.value));
          if (out_word.last !== want.last)
            report_mismatch($sformatf("last: got %b, expected %b",
                                      out_word.last, want.last));
        end
      end
    end
  end

  // Driver: offers queued bytes, with random idle bursts between them.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0 && send_idle_pct != 0 &&
                   $urandom_range(99) < send_idle_pct) begin
        send_gap = $urandom_range(16, 0);
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_word  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off that backs up the input.
  int   stall_left = 0;
  int   hold_left = 0;
  logic long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= 120) begin
      long_hold_done = 1'b1;
      hold_left = 79;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      stall_left = $urandom_range(16, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic r);
    in_word_t w;
    w.data_byte = b;
    w.realign   = r;
    pending_bytes.push_back(w);
  endtask

  // Waits until every byte is taken and every value has arrived, then lets
  // the block finish any byte that produced nothing.
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_setting(input logic [1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [1:0]  phase_setting[6];
    int          phase_send[6];
    int          phase_recv[6];
    logic [31:0] stream_bits;
    int          stream_len;
    int          mode;
    logic [7:0]  b;
    logic        r;

    phase_setting = '{PerValueWord, PerValueByte, PerValueHalf, PerValueClamped,
                      PerValueWord, PerValueHalf};
    phase_send = '{25, 0, 40, 10, 25, 0};
    phase_recv = '{25, 0, 10, 40, 25, 0};
    stream_bits = '0;
    stream_len  = 0;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: runs of short codes that finish three values in one byte,
    // long codes of all ones and zeros, codes across byte boundaries, realign.
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    write_setting(PerValueByte);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h01, 1'b0);
    settle();
    write_setting(PerValueClamped);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h24, 1'b0);
    // A short code is left unfinished on purpose; its last bit comes in the next
    // byte, which is decoded under the narrower setting.
    settle();
    write_setting(PerValueHalf);
    push_byte(8'h6D, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    settle();
    write_setting(PerValueWord);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hB6, 1'b0);
    push_byte(8'hFE, 1'b1);
    settle();

    // Random part: mostly a well-formed code stream, biased to short codes so
    // that bytes often finish three values, mixed with raw bytes and realigns.
    for (int p = 0; p < 6; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      write_setting(phase_setting[p]);
      for (int n = 0; n < 80; n++) begin
        mode = $urandom_range(9);
        r = ($urandom_range(19) == 0);
        if (mode <= 5) begin
          while (stream_len < 8) begin
            if ($urandom_range(3) != 0) begin
              stream_bits = (stream_bits << 3) | 32'($urandom_range(3));
              stream_len += 3;
            end else begin
              stream_bits = (stream_bits << 9) | 32'h100 | 32'($urandom_range(255));
              stream_len += 9;
            end
          end
          b = 8'(stream_bits >> (stream_len - 8));
          stream_len -= 8;
        end else if (mode <= 7) begin
          b = 8'($urandom_range(255));
        end else if (mode == 8) begin
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          b = 8'($urandom_range(255));
          r = 1'b1;
        end
        push_byte(b, r);
      end
      if (p < 5) settle();
    end

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    for (int c = 0; c < 2000 && expected_values.size() != 0; c++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_values.size() != 0)
      report_mismatch($sformatf("%0d expected values never arrived",
                                expected_values.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
